// ----- sv/sdf32_pkg.sv -----
// ============================================================================
// sdf32_pkg
// Shared types, constants and binary-to-decimal helpers for the signed
// decimal field renderer.
// ============================================================================
package sdf32_pkg;

    localparam int BIN_W           = 32;
    localparam int MAX_DIGITS      = 10;
    localparam int BCD_W           = 4 * MAX_DIGITS;
    localparam int WORK_W          = BCD_W + BIN_W;
    localparam int POS_W           = 4;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DABBLE_STAGES   = BIN_W / STEPS_PER_STAGE;
    localparam int DIGIT_COUNT_DEF = 10;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [5:0] CHAR_SPACE = 6'd32;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    localparam logic [1:0] COLOR_DEFAULT = 2'd0;
    localparam logic [1:0] COLOR_NORMAL  = 2'd1;
    localparam logic [1:0] COLOR_CURSOR  = 2'd2;

    typedef struct packed {
        logic [WORK_W-1:0] work;   // {bcd digits, binary remainder}
        logic              neg;
        logic [6:0]        col;
        logic [3:0]        row;
        logic              sel;
        logic [3:0]        cursor;
    } item_t;

    // one shift-and-add-3 step
    function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] x);
        logic [WORK_W-1:0] y;
        y = x;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (y[BIN_W + 4*d +: 4] >= 4'd5) begin
                y[BIN_W + 4*d +: 4] = y[BIN_W + 4*d +: 4] + 4'd3;
            end
        end
        return {y[WORK_W-2:0], 1'b0};
    endfunction

    function automatic logic [WORK_W-1:0] dabble_stage(input logic [WORK_W-1:0] x);
        logic [WORK_W-1:0] y;
        y = x;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            y = dabble_step(y);
        end
        return y;
    endfunction

endpackage

// ----- sv/signed_decimal_field_32.sv -----
// ============================================================================
// signed_decimal_field_32
// Renders a signed 32-bit value as a sign cell plus decimal digit cells.
// ============================================================================
// Input beat (s_*): one value with its text position, edit flag and cursor.
// Output beats (m_*): DIGIT_COUNT+1 character cells per input beat, the sign
// cell first, then the digits most significant first; m_tlast marks the final
// digit cell.
// Path: an accepted input beat passes the magnitude stage, four conversion
// stages, the serializer and the output register before its sign cell shows
// on m_*.
// Throughput: one cell per cycle while m_tready is high, DIGIT_COUNT+1 cells
// per input beat (11 at the default). The conversion pipeline keeps taking
// input beats while the serializer drains a field, up to five fields ahead.
// Reset: all valid bits and the cell counter clear; no beat is lost or
// emitted after reset is released.
// Stall: when m_tready is low the output register holds, the serializer and
// pipeline stop as they fill, and s_tready drops once every stage is occupied.
// ============================================================================
module signed_decimal_field_32 #(
    parameter int DIGIT_COUNT = sdf32_pkg::DIGIT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value[31:0], column_start[38:32], text_row[42:39], selected[43],
    // cursor_digit[47:44]
    input  logic [sdf32_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // char_code[5:0], color_class[7:6], pixel_column[15:8], pixel_row[23:16]
    output logic [sdf32_pkg::M_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import sdf32_pkg::*;

    localparam int PIPE_N = DABBLE_STAGES + 1;
    localparam int CELL_W = $clog2(DIGIT_COUNT + 1);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(DIGIT_COUNT);

    item_t             pipe_reg  [PIPE_N];
    item_t             pipe_next [PIPE_N];
    logic [PIPE_N-1:0] vld_reg, vld_next;
    logic [PIPE_N:0]   take;

    item_t             ser_reg;
    logic              ser_vld_reg, ser_vld_next;
    logic [CELL_W-1:0] cell_idx_reg, cell_idx_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [5:0]        char_reg, char_next;
    logic [1:0]        color_reg, color_next;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic              last_reg, last_next;

    logic              out_free, emit, ser_done;
    logic [BIN_W-1:0]  mag;
    logic [POS_W-1:0]  pos;
    logic [3:0]        digits [MAX_DIGITS];

    // handshake chain
    always_comb begin
        out_free     = !m_tvalid_reg || m_tready;
        emit         = ser_vld_reg && out_free;
        ser_done     = emit && (cell_idx_reg == LAST_CELL);
        take[PIPE_N] = !ser_vld_reg || ser_done;
        for (int k = PIPE_N - 1; k >= 0; k--) begin
            take[k] = !vld_reg[k] || take[k+1];
        end
    end

    assign s_tready = take[0];

    // pipeline data and valids
    always_comb begin
        mag = s_tdata[BIN_W-1] ? (BIN_W'(0) - s_tdata[BIN_W-1:0]) : s_tdata[BIN_W-1:0];
        pipe_next[0].work   = {{BCD_W{1'b0}}, mag};
        pipe_next[0].neg    = s_tdata[BIN_W-1];
        pipe_next[0].col    = s_tdata[38:32];
        pipe_next[0].row    = s_tdata[42:39];
        pipe_next[0].sel    = s_tdata[43];
        pipe_next[0].cursor = s_tdata[47:44];
        vld_next[0]         = take[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < PIPE_N; k++) begin
            pipe_next[k]      = pipe_reg[k-1];
            pipe_next[k].work = dabble_stage(pipe_reg[k-1].work);
            vld_next[k]       = take[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PIPE_N; k++) begin
            if (take[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (take[PIPE_N]) begin
            ser_reg <= pipe_reg[PIPE_N-1];
        end
    end

    // serializer
    always_comb begin
        ser_vld_next  = take[PIPE_N] ? vld_reg[PIPE_N-1] : ser_vld_reg;
        cell_idx_next = cell_idx_reg;
        if (emit) begin
            cell_idx_next = ser_done ? '0 : cell_idx_reg + CELL_W'(1);
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            digits[d] = ser_reg.work[BIN_W + 4*d +: 4];
        end
        pos = POS_W'(DIGIT_COUNT) - POS_W'(cell_idx_reg);
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        color_next    = color_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        last_next     = last_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            col_next      = 8'(ser_reg.col) + 8'({cell_idx_reg, 3'b000});
            row_next      = {ser_reg.row, 4'b0000};
            last_next     = (cell_idx_reg == LAST_CELL);
            if (cell_idx_reg == '0) begin
                char_next  = ser_reg.neg ? CHAR_MINUS : CHAR_SPACE;
                color_next = COLOR_DEFAULT;
            end else begin
                char_next  = CHAR_ZERO + {2'b00, digits[pos]};
                if (!ser_reg.sel) begin
                    color_next = COLOR_DEFAULT;
                end else if (pos == ser_reg.cursor) begin
                    color_next = COLOR_CURSOR;
                end else begin
                    color_next = COLOR_NORMAL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            ser_vld_reg  <= 1'b0;
            cell_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            ser_vld_reg  <= ser_vld_next;
            cell_idx_reg <= cell_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        char_reg  <= char_next;
        color_reg <= color_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {row_reg, col_reg, color_reg, char_reg};
    assign m_tlast  = last_reg;

    // assertions
    a_cell_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_idx_reg <= LAST_CELL)
        else $error("cell index past last cell");

    a_field_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_done |=> cell_idx_reg == '0)
        else $error("cell index did not wrap after last cell");

    a_sign_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (!m_tvalid || m_tdata[5:0] == CHAR_SPACE || m_tdata[5:0] == CHAR_MINUS))
        else $error("field did not start with a sign cell");

    a_sign_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[5:0] == CHAR_SPACE || m_tdata[5:0] == CHAR_MINUS))
            |-> (m_tdata[7:6] == COLOR_DEFAULT && !m_tlast))
        else $error("sign cell with wrong color or last flag");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (vld_reg[0] && ser_vld_reg))
        else $error("input stalled with empty stage");

endmodule
